// ===== design/nsc_pkg.sv =====
// Package with the types, character constants and helpers of the NMEA sentence checker.
package nsc_pkg;

    localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
    localparam logic [7:0] CHAR_STAR     = 8'h2A;
    localparam logic [7:0] CHAR_COMMA    = 8'h2C;
    localparam logic [7:0] CHAR_T        = 8'h54;
    localparam logic [7:0] CHAR_0        = 8'h30;
    localparam logic [7:0] CHAR_9        = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
    localparam logic [23:0] TAG_PREFIX   = 24'h4B5358;
    localparam logic [7:0] FIELDS_RESET  = 8'd23;
    localparam logic [7:0] TALLY_MAX     = 8'hFF;

    localparam logic [0:0] REG_EXPECTED_FIELDS = 1'b0;

    typedef enum logic [2:0] {
        PH_SEEK    = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_HEX1    = 3'd2,
        PH_HEX2    = 3'd3,
        PH_GOOD    = 3'd4,
        PH_BAD     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_NO_HEADER     = 3'd0,
        ST_NO_TERMINATOR = 3'd1,
        ST_CHECKSUM_BAD  = 3'd2,
        ST_FIELDS_WRONG  = 3'd3,
        ST_TAG_MISSING   = 3'd4,
        ST_OK            = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } nsc_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] computed_sum;
        logic [7:0] field_total;
    } nsc_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d.value = 4'(c - CHAR_0);
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            d.value = 4'(c - CHAR_UPPER_A + 8'd10);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            d.value = 4'(c - CHAR_LOWER_A + 8'd10);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== design/nmea_sentence_checker_unit.sv =====
// Top level of the NMEA sentence checker: byte-wise checksum, field count and tag check.
//
// Channel  Direction  Handshake           Payload
// in       request    in_valid/in_ready   in_data   (data_byte, last_byte)
// out      result     out_valid/out_ready out_data  (status, computed_sum, field_total)
// cfg      APB write  psel/penable/pwrite paddr, pwdata, prdata
//
// A request is held in the input register, and the state update writes a last byte's result into the
// result register; one byte per cycle is sustained while the result register is not stalled.
// The rate is set by the state update between the input and result registers.
// Reset clears the sentence state, both valid flags and sets expected_fields to 23.
// A stalled result holds the state update; the input register then fills and in_ready drops.
module nmea_sentence_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nsc_pkg::nsc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nsc_pkg::nsc_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              in_valid_reg;
    nsc_pkg::nsc_in_t  in_reg;
    logic              out_valid_reg;
    nsc_pkg::nsc_out_t out_reg;
    logic [7:0]        expected_fields_reg;

    nsc_pkg::phase_t   phase_reg;
    nsc_pkg::phase_t   phase_next;
    logic [7:0]        xor_reg;
    logic [7:0]        xor_next;
    logic [7:0]        comma_reg;
    logic [7:0]        comma_next;
    logic [23:0]       tag_window_reg;
    logic [23:0]       tag_window_next;
    logic              tag_seen_reg;
    logic              tag_seen_next;
    logic              first_open_reg;
    logic              first_open_next;
    logic [3:0]        high_nibble_reg;
    logic [3:0]        high_nibble_next;

    logic              advance;
    logic              cfg_write;
    nsc_pkg::hex_digit_t hex;
    logic [7:0]        byte_c;
    logic [7:0]        total;
    nsc_pkg::status_t  status;
    nsc_pkg::nsc_out_t result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == nsc_pkg::REG_EXPECTED_FIELDS) ?
                       {24'd0, expected_fields_reg} : 32'd0;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign byte_c = in_reg.data_byte;
    assign hex    = nsc_pkg::hex_decode(byte_c);

    always_comb
    begin
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        comma_next       = comma_reg;
        tag_window_next  = tag_window_reg;
        tag_seen_next    = tag_seen_reg;
        first_open_next  = first_open_reg;
        high_nibble_next = high_nibble_reg;
        case (phase_reg)
            nsc_pkg::PH_SEEK:
            begin
                if (byte_c == nsc_pkg::CHAR_DOLLAR)
                begin
                    phase_next = nsc_pkg::PH_PAYLOAD;
                end
            end
            nsc_pkg::PH_PAYLOAD:
            begin
                if (byte_c == nsc_pkg::CHAR_STAR)
                begin
                    phase_next = nsc_pkg::PH_HEX1;
                end
                else
                begin
                    xor_next = xor_reg ^ byte_c;
                    if (byte_c == nsc_pkg::CHAR_COMMA)
                    begin
                        if (comma_reg != nsc_pkg::TALLY_MAX)
                        begin
                            comma_next = comma_reg + 8'd1;
                        end
                        first_open_next = 1'b0;
                    end
                    else if (first_open_reg)
                    begin
                        if (byte_c == nsc_pkg::CHAR_T && tag_window_reg == nsc_pkg::TAG_PREFIX)
                        begin
                            tag_seen_next = 1'b1;
                        end
                        tag_window_next = {tag_window_reg[15:0], byte_c};
                    end
                end
            end
            nsc_pkg::PH_HEX1:
            begin
                if (hex.ok)
                begin
                    high_nibble_next = hex.value;
                    phase_next       = nsc_pkg::PH_HEX2;
                end
                else
                begin
                    phase_next = nsc_pkg::PH_BAD;
                end
            end
            nsc_pkg::PH_HEX2:
            begin
                if (hex.ok)
                begin
                    phase_next = (xor_reg == {high_nibble_reg, hex.value}) ?
                                 nsc_pkg::PH_GOOD : nsc_pkg::PH_BAD;
                end
                else
                begin
                    phase_next = (xor_reg == {4'd0, high_nibble_reg}) ?
                                 nsc_pkg::PH_GOOD : nsc_pkg::PH_BAD;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        total = (comma_next == nsc_pkg::TALLY_MAX) ? nsc_pkg::TALLY_MAX : comma_next + 8'd1;
        if (phase_next == nsc_pkg::PH_SEEK)
        begin
            status = nsc_pkg::ST_NO_HEADER;
        end
        else if (phase_next == nsc_pkg::PH_PAYLOAD)
        begin
            status = nsc_pkg::ST_NO_TERMINATOR;
        end
        else if (phase_next != nsc_pkg::PH_GOOD)
        begin
            status = nsc_pkg::ST_CHECKSUM_BAD;
        end
        else if (total != expected_fields_reg)
        begin
            status = nsc_pkg::ST_FIELDS_WRONG;
        end
        else if (!tag_seen_next)
        begin
            status = nsc_pkg::ST_TAG_MISSING;
        end
        else
        begin
            status = nsc_pkg::ST_OK;
        end
        result.status = status;
        if (status == nsc_pkg::ST_NO_HEADER)
        begin
            result.computed_sum = 8'd0;
            result.field_total  = 8'd0;
        end
        else
        begin
            result.computed_sum = xor_next;
            result.field_total  = total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_fields_reg <= nsc_pkg::FIELDS_RESET;
        end
        else if (cfg_write && paddr[2] == nsc_pkg::REG_EXPECTED_FIELDS)
        begin
            expected_fields_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_reg.last_byte;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_reg.last_byte)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= nsc_pkg::PH_SEEK;
            xor_reg         <= 8'd0;
            comma_reg       <= 8'd0;
            tag_window_reg  <= 24'd0;
            tag_seen_reg    <= 1'b0;
            first_open_reg  <= 1'b1;
            high_nibble_reg <= 4'd0;
        end
        else if (advance)
        begin
            if (in_reg.last_byte)
            begin
                phase_reg       <= nsc_pkg::PH_SEEK;
                xor_reg         <= 8'd0;
                comma_reg       <= 8'd0;
                tag_window_reg  <= 24'd0;
                tag_seen_reg    <= 1'b0;
                first_open_reg  <= 1'b1;
                high_nibble_reg <= 4'd0;
            end
            else
            begin
                phase_reg       <= phase_next;
                xor_reg         <= xor_next;
                comma_reg       <= comma_next;
                tag_window_reg  <= tag_window_next;
                tag_seen_reg    <= tag_seen_next;
                first_open_reg  <= first_open_next;
                high_nibble_reg <= high_nibble_next;
            end
        end
    end

    // A stalled input side only happens behind a full, stalled result register.
    a_ready_low_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a blocked result");

    // A last byte rearms the sentence state.
    a_rearm_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.last_byte) |=>
        (phase_reg == nsc_pkg::PH_SEEK && xor_reg == 8'd0 && comma_reg == 8'd0
         && !tag_seen_reg && first_open_reg))
        else $error("state not rearmed after last byte");

    // A sentence without header reports zero sum and zero field total.
    a_no_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == nsc_pkg::ST_NO_HEADER) |->
        (out_data.computed_sum == 8'd0 && out_data.field_total == 8'd0))
        else $error("no-header result carries nonzero fields");

    // Once a header is seen the field total is at least one.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != nsc_pkg::ST_NO_HEADER) |->
        (out_data.field_total != 8'd0))
        else $error("field total zero after header");

    // The tag can only be found while the first field is still open.
    a_tag_in_first_field: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_reg.last_byte && !tag_seen_reg && !first_open_reg) |=> !tag_seen_reg)
        else $error("tag detected outside the first field");

endmodule
